[hw/rtl/bpu_pkg.sv]
// ----------------------------------------------------------------------------
// bpu_pkg
// Types and constants shared by the branch predictor modules.
// ----------------------------------------------------------------------------
package bpu_pkg;

    localparam int NumEntries = 32;
    localparam int EntryAw    = 5;
    localparam int MaxHistory = 8;
    localparam int RowLen     = 1 << MaxHistory;
    localparam int RowW       = 2 * RowLen;
    localparam int NumRows    = NumEntries + 1;   // local rows plus the shared row
    localparam int RowAw      = 6;
    localparam int TagW       = 30;

    localparam logic [RowAw-1:0] GlobalRow = RowAw'(NumEntries);

    typedef enum logic [2:0] {
        CFG_LOG_ENTRIES  = 3'd0,
        CFG_HISTORY_LEN  = 3'd1,
        CFG_TAG_LEN      = 3'd2,
        CFG_COUNTER_INIT = 3'd3,
        CFG_USE_GHIST    = 3'd4,
        CFG_USE_GTABLE   = 3'd5,
        CFG_SHARE_MODE   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_LOW  = 2'd1,
        SHARE_MID  = 2'd2
    } t_share;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] branch_pc;
        logic [31:0] resolved_target;
        logic        resolved_taken;
        logic [31:0] earlier_prediction;
    } t_req;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] predict_target;
        logic        flushed;
        logic [31:0] flush_count;
        logic [31:0] branch_count;
    } t_rsp;

    typedef struct packed {
        logic [TagW-1:0]       tag;
        logic [31:0]           target;
        logic [MaxHistory-1:0] hist;
    } t_entry;

endpackage

[hw/rtl/btb_two_level_branch_predictor_top.sv]
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_top
// Direct-mapped BTB with a two-level predictor of 2-bit saturating counters.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, i_req                   taken when start && !busy
//  result    o_valid, o_result              one-cycle strobe, no stall
//  config    i_cfg_we, i_cfg_idx, i_cfg_data  write on i_cfg_we
//
// A request passes the entry memory read, the counter row read, then for an
// update the row/entry write-back; the result strobes on the cycle after that,
// when the next request may already be taken: the two dependent memory reads
// keep a new request out until then. Reset is synchronous; counter rows and
// entries are marked invalid at once by flip-flop valid bits, so no clearing
// pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bpu_pkg::t_req     i_req,
    output logic              o_valid,
    output bpu_pkg::t_rsp     o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [4:0]        i_cfg_data
);
    import bpu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ENT  = 3'b010,
        ST_ROW  = 3'b100
    } t_state;

    t_state r_state;

    logic [2:0] r_cfg_log;
    logic [3:0] r_cfg_hlen;
    logic [4:0] r_cfg_tlen;
    logic [1:0] r_cfg_init;
    logic       r_cfg_ghist;
    logic       r_cfg_gtable;
    logic [1:0] r_cfg_share;

    logic [NumEntries-1:0] r_ent_valid;
    logic [NumRows-1:0]    r_row_valid;
    logic [MaxHistory-1:0] r_ghist;
    logic [31:0]           r_flush_total;
    logic [31:0]           r_branch_total;

    t_req                  r_req;
    logic [EntryAw-1:0]    r_idx;
    logic                  r_hit;
    logic [MaxHistory-1:0] r_hist;
    logic [MaxHistory-1:0] r_ci;
    logic [RowAw-1:0]      r_row;
    logic                  r_row_init;

    logic r_out_valid;
    t_rsp r_out;

    // effective configuration
    logic [2:0]            eff_log;
    logic [3:0]            eff_hist;
    logic [4:0]            tl_max;
    logic [4:0]            eff_tl;
    logic [MaxHistory-1:0] hmask;
    logic [TagW-1:0]       tmask;
    logic [EntryAw-1:0]    imask;

    assign eff_log  = (r_cfg_log > 3'd5) ? 3'd5 : r_cfg_log;
    assign eff_hist = (r_cfg_hlen == 4'd0) ? 4'd1 :
                      (r_cfg_hlen > 4'(MaxHistory)) ? 4'(MaxHistory) : r_cfg_hlen;
    assign tl_max   = 5'd30 - 5'(eff_log);
    assign eff_tl   = (r_cfg_tlen > tl_max) ? tl_max : r_cfg_tlen;
    assign hmask    = MaxHistory'((9'd1 << eff_hist) - 9'd1);
    assign tmask    = TagW'((31'd1 << eff_tl) - 31'd1);
    assign imask    = EntryAw'((6'd1 << eff_log) - 6'd1);

    logic          accept;
    logic [EntryAw-1:0] in_idx;
    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign in_idx = i_req.branch_pc[EntryAw+1:2] & imask;

    // memories
    t_entry          ent_q;
    t_entry          ent_wdata;
    logic            ent_we;
    logic [RowW-1:0] row_q;
    logic [RowW-1:0] row_wdata;
    logic            row_we;
    logic            row_re;
    logic [RowAw-1:0] row_raddr;

    bpu_entry_mem u_ent (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_idx),
        .i_wdata (ent_wdata),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ent_q)
    );

    bpu_ctr_mem u_ctr (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_row),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_q)
    );

    // entry stage: tag check, history select, counter index
    logic                  is_upd;
    logic [TagW-1:0]       pc_tag;
    logic                  hit;
    logic [MaxHistory-1:0] stored_hist;
    logic [MaxHistory-1:0] hist;
    logic [MaxHistory-1:0] share_bits;
    logic [MaxHistory-1:0] ci;
    logic [31:0]           pc_shift;

    assign is_upd      = (r_req.opcode == OP_UPDATE);
    assign pc_shift    = r_req.branch_pc >> (6'd2 + 6'(eff_log));
    assign pc_tag      = pc_shift[TagW-1:0] & tmask;
    assign hit         = r_ent_valid[r_idx] && (ent_q.tag == pc_tag);
    assign stored_hist = r_ent_valid[r_idx] ? ent_q.hist : '0;

    always_comb begin
        if (r_cfg_ghist) begin
            hist = r_ghist;
        end else if (is_upd && !hit) begin
            hist = '0;
        end else begin
            hist = stored_hist;
        end
        case (r_cfg_share)
            SHARE_LOW: share_bits = r_req.branch_pc[MaxHistory+1:2];
            SHARE_MID: share_bits = r_req.branch_pc[MaxHistory+15:16];
            default:   share_bits = '0;
        endcase
        ci = (hist ^ share_bits) & hmask;
    end

    assign row_re    = (r_state == ST_ENT);
    assign row_raddr = r_cfg_gtable ? GlobalRow : RowAw'(r_idx);

    // row stage: counter read, train, write back
    logic [RowW-1:0]       eff_row;
    logic [1:0]            ctr;
    logic [1:0]            ctr_next;
    logic [31:0]           pc_next;
    logic                  mis;
    logic [MaxHistory-1:0] hist_next;

    assign eff_row = r_row_init ? {RowLen{r_cfg_init}} : row_q;
    assign ctr     = eff_row[{r_ci, 1'b0} +: 2];
    assign pc_next = r_req.branch_pc + 32'd4;
    assign mis     = r_req.resolved_taken ? (r_req.earlier_prediction != r_req.resolved_target)
                                          : (r_req.earlier_prediction != pc_next);
    assign hist_next = {r_hist[MaxHistory-2:0], r_req.resolved_taken} & hmask;

    always_comb begin
        if (r_req.resolved_taken) begin
            ctr_next = (ctr == 2'd3) ? ctr : ctr + 2'd1;
        end else begin
            ctr_next = (ctr == 2'd0) ? ctr : ctr - 2'd1;
        end
        row_wdata = eff_row;
        row_wdata[{r_ci, 1'b0} +: 2] = ctr_next;
    end

    logic upd_now;
    assign upd_now = (r_state == ST_ROW) && is_upd;
    assign row_we  = upd_now;
    assign ent_we  = upd_now;

    always_comb begin
        ent_wdata.tag    = pc_tag;
        ent_wdata.target = (!r_hit || mis) ? r_req.resolved_target
                         : (r_ent_valid[r_idx] ? ent_q.target : '0);
        if (r_cfg_ghist) begin
            ent_wdata.hist = stored_hist;
        end else begin
            ent_wdata.hist = hist_next;
        end
    end

    t_rsp rsp;
    logic [31:0] flush_nxt;
    logic [31:0] branch_nxt;
    assign flush_nxt  = r_flush_total + (mis ? 32'd1 : 32'd0);
    assign branch_nxt = r_branch_total + 32'd1;

    always_comb begin
        rsp = '0;
        if (is_upd) begin
            rsp.flushed      = mis;
            rsp.flush_count  = flush_nxt;
            rsp.branch_count = branch_nxt;
        end else begin
            rsp.predict_taken  = r_hit && ctr[1];
            rsp.predict_target = (r_hit && ctr[1]) ? ent_q.target : pc_next;
            rsp.flush_count    = r_flush_total;
            rsp.branch_count   = r_branch_total;
        end
    end

    // sequencer and state
    t_state n_state;
    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = accept ? ST_ENT : ST_IDLE;
            ST_ENT:  n_state = ST_ROW;
            ST_ROW:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cfg_log      <= 3'd5;
            r_cfg_hlen     <= 4'd8;
            r_cfg_tlen     <= 5'd25;
            r_cfg_init     <= 2'd1;
            r_cfg_ghist    <= 1'b0;
            r_cfg_gtable   <= 1'b0;
            r_cfg_share    <= SHARE_NONE;
            r_ent_valid    <= '0;
            r_row_valid    <= '0;
            r_ghist        <= '0;
            r_flush_total  <= '0;
            r_branch_total <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_ROW);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LOG_ENTRIES:  r_cfg_log    <= i_cfg_data[2:0];
                    CFG_HISTORY_LEN:  r_cfg_hlen   <= i_cfg_data[3:0];
                    CFG_TAG_LEN:      r_cfg_tlen   <= i_cfg_data;
                    CFG_COUNTER_INIT: begin
                        r_cfg_init  <= i_cfg_data[1:0];
                        r_row_valid <= '0;   // every row reads back as the new init
                    end
                    CFG_USE_GHIST:    r_cfg_ghist  <= i_cfg_data[0];
                    CFG_USE_GTABLE:   r_cfg_gtable <= i_cfg_data[0];
                    CFG_SHARE_MODE:   r_cfg_share  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (upd_now) begin
                r_ent_valid[r_idx] <= 1'b1;
                r_row_valid[r_row] <= 1'b1;
                r_flush_total      <= flush_nxt;
                r_branch_total     <= branch_nxt;
                if (r_cfg_ghist) begin
                    r_ghist <= hist_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_idx <= in_idx;
        end
        if (r_state == ST_ENT) begin
            r_hit      <= hit;
            r_hist     <= hist;
            r_ci       <= ci;
            r_row      <= row_raddr;
            // a fresh allocation restarts its local row from the init value
            r_row_init <= !r_row_valid[row_raddr] || (is_upd && !hit && !r_cfg_gtable);
        end
        if (r_state == ST_ROW) begin
            r_out <= rsp;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_result_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW) |=> o_valid)
        else $error("result strobe missing after row stage");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_flush_update_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.flushed) |-> !o_result.predict_taken)
        else $error("flush reported with a taken prediction");

endmodule

[hw/rtl/bpu_entry_mem.sv]
// ----------------------------------------------------------------------------
// bpu_entry_mem
// Entry store: tag, target and local history, one write and one registered read.
// ----------------------------------------------------------------------------
module bpu_entry_mem (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [bpu_pkg::EntryAw-1:0] i_waddr,
    input  bpu_pkg::t_entry        i_wdata,
    input  logic                   i_re,
    input  logic [bpu_pkg::EntryAw-1:0] i_raddr,
    output bpu_pkg::t_entry        o_rdata
);
    import bpu_pkg::*;

    t_entry r_mem [0:NumEntries-1];
    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

[hw/rtl/bpu_ctr_mem.sv]
// ----------------------------------------------------------------------------
// bpu_ctr_mem
// Counter rows: one row of 2-bit counters per entry plus the shared row.
// ----------------------------------------------------------------------------
module bpu_ctr_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bpu_pkg::RowAw-1:0]  i_waddr,
    input  logic [bpu_pkg::RowW-1:0]   i_wdata,
    input  logic                       i_re,
    input  logic [bpu_pkg::RowAw-1:0]  i_raddr,
    output logic [bpu_pkg::RowW-1:0]   o_rdata
);
    import bpu_pkg::*;

    logic [RowW-1:0] r_mem [0:NumRows-1];
    logic [RowW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

[tb/btb_two_level_branch_predictor_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_top_test
// Drives predict/update requests through several register settings, keeps
// its own model of the BTB and counter tables, and checks every result.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_top_test;
    import bpu_pkg::*;

    localparam int CycleLimit = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_valid;
    t_rsp        o_result;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [4:0]  i_cfg_data = '0;

    btb_two_level_branch_predictor_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model state
    logic [2:0]  m_log;
    logic [3:0]  m_hlen;
    logic [4:0]  m_tlen;
    logic [1:0]  m_init;
    logic        m_ghist_on, m_gtable_on;
    logic [1:0]  m_share;
    logic        m_valid  [NumEntries];
    logic [29:0] m_tag    [NumEntries];
    logic [31:0] m_target [NumEntries];
    logic [7:0]  m_lhist  [NumEntries];
    logic [7:0]  m_ghist;
    logic [1:0]  m_lctr   [NumEntries][RowLen];
    logic [1:0]  m_gctr   [RowLen];
    logic [31:0] m_flushes, m_branches;

    t_req pending_q[$];
    t_rsp expected_q[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   gap_left = 0;
    bit   quiet = 0;
    int unsigned pc_pool[16];
    int unsigned tgt_pool[16];

    function automatic void refill_counters();
        for (int e = 0; e < NumEntries; e++)
            for (int c = 0; c < RowLen; c++) m_lctr[e][c] = m_init;
        for (int c = 0; c < RowLen; c++) m_gctr[c] = m_init;
    endfunction

    function automatic void model_reset();
        m_log = 3'd5; m_hlen = 4'd8; m_tlen = 5'd25; m_init = 2'd1;
        m_ghist_on = 0; m_gtable_on = 0; m_share = SHARE_NONE;
        for (int e = 0; e < NumEntries; e++) begin
            m_valid[e] = 0; m_tag[e] = '0; m_target[e] = '0; m_lhist[e] = '0;
        end
        m_ghist = '0; m_flushes = '0; m_branches = '0;
        refill_counters();
    endfunction

    function automatic void model_write(t_cfg_idx idx, logic [4:0] val);
        case (idx)
            CFG_LOG_ENTRIES:  m_log = val[2:0];
            CFG_HISTORY_LEN:  m_hlen = val[3:0];
            CFG_TAG_LEN:      m_tlen = val;
            CFG_COUNTER_INIT: begin
                m_init = val[1:0];
                refill_counters();
            end
            CFG_USE_GHIST:    m_ghist_on = val[0];
            CFG_USE_GTABLE:   m_gtable_on = val[0];
            CFG_SHARE_MODE:   m_share = val[1:0];
            default: ;
        endcase
    endfunction

    // one request through the model; returns the result it must produce
    function automatic t_rsp btb_step(t_req r);
        int unsigned le, hl, tl, idx, tagv, hmask, hist, ci, nxt;
        bit hit, mis;
        logic [1:0] ctr;
        t_rsp rsp;
        le = (m_log > 5) ? 5 : m_log;
        hl = (m_hlen == 0) ? 1 : ((m_hlen > MaxHistory) ? MaxHistory : m_hlen);
        tl = (m_tlen > 30 - le) ? 30 - le : m_tlen;
        hmask = (1 << hl) - 1;
        idx = (r.branch_pc >> 2) & ((1 << le) - 1);
        tagv = (r.branch_pc >> (2 + le)) & ((1 << tl) - 1);
        nxt = r.branch_pc + 32'd4;
        hit = m_valid[idx] && (m_tag[idx] == tagv[29:0]);
        rsp = '0;
        if (r.opcode == OP_UPDATE && !hit) begin
            m_valid[idx] = 1; m_tag[idx] = tagv[29:0]; m_target[idx] = r.resolved_target;
            if (!m_ghist_on) m_lhist[idx] = '0;
            if (!m_gtable_on)
                for (int c = 0; c < RowLen; c++) m_lctr[idx][c] = m_init;
        end
        hist = m_ghist_on ? m_ghist : m_lhist[idx];
        ci = hist & hmask;
        if (m_share == SHARE_LOW) ci = ci ^ ((r.branch_pc >> 2) & hmask);
        else if (m_share == SHARE_MID) ci = ci ^ ((r.branch_pc >> 16) & hmask);
        ci = ci & hmask;
        ctr = m_gtable_on ? m_gctr[ci] : m_lctr[idx][ci];
        if (r.opcode == OP_PREDICT) begin
            rsp.predict_target = nxt;
            if (hit && ctr >= 2) begin
                rsp.predict_taken = 1;
                rsp.predict_target = m_target[idx];
            end
        end else begin
            mis = r.resolved_taken ? (r.earlier_prediction != r.resolved_target)
                                   : (r.earlier_prediction != nxt);
            if (mis) begin
                m_flushes++;
                m_target[idx] = r.resolved_target;
            end
            if (r.resolved_taken && ctr < 3) ctr++;
            else if (!r.resolved_taken && ctr > 0) ctr--;
            if (m_gtable_on) m_gctr[ci] = ctr;
            else m_lctr[idx][ci] = ctr;
            hist = ((hist << 1) | r.resolved_taken) & hmask;
            if (m_ghist_on) m_ghist = hist[7:0];
            else m_lhist[idx] = hist[7:0];
            m_branches++;
            rsp.flushed = mis;
        end
        rsp.flush_count = m_flushes;
        rsp.branch_count = m_branches;
        return rsp;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_q.push_back(btb_step(i_req));
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_q.size() > 0 && !quiet
                             && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 9) - 1;
                    start <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    i_req <= pending_q.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_result);
            end else begin
                want = expected_q.pop_front();
                if (o_result.predict_taken !== want.predict_taken
                    || o_result.predict_target !== want.predict_target
                    || o_result.flushed !== want.flushed
                    || o_result.flush_count !== want.flush_count
                    || o_result.branch_count !== want.branch_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp tk=%0d tgt=%h fl=%0d fc=%0d bc=%0d,",
                                  " got tk=%0d tgt=%h fl=%0d fc=%0d bc=%0d"},
                                 want.predict_taken, want.predict_target, want.flushed,
                                 want.flush_count, want.branch_count,
                                 o_result.predict_taken, o_result.predict_target,
                                 o_result.flushed, o_result.flush_count,
                                 o_result.branch_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_req(logic op, logic [31:0] pc, logic [31:0] tgt, logic tk,
                           logic [31:0] ep);
        t_req r;
        r.opcode = op; r.branch_pc = pc; r.resolved_target = tgt;
        r.resolved_taken = tk; r.earlier_prediction = ep;
        pending_q.push_back(r);
    endtask

    task automatic write_all(logic [4:0] v0, logic [4:0] v1, logic [4:0] v2,
                             logic [4:0] v3, logic [4:0] v4, logic [4:0] v5,
                             logic [4:0] v6);
        logic [4:0] vals[7];
        vals = '{v0, v1, v2, v3, v4, v5, v6};
        for (int k = 0; k < 7; k++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= k[2:0];
            i_cfg_data <= vals[k];
            model_write(t_cfg_idx'(k), vals[k]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_q.size() > 0 || start || expected_q.size() > 0);
        repeat (8) @(posedge i_clk);
    endtask

    // well-formed traffic on a small pool of branches, with some noise
    task automatic random_items(int count);
        int p;
        logic [31:0] pc, tgt, ep;
        logic tk;
        for (int k = 0; k < 16; k++) begin
            pc_pool[k] = $urandom;
            tgt_pool[k] = $urandom;
        end
        // alias some entries: same index, different tag where the tag covers the flipped bit
        for (int k = 8; k < 12; k++) pc_pool[k] = pc_pool[k - 8] ^ (32'h1 << $urandom_range(7, 31));
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, 15);
            pc = ($urandom_range(0, 9) == 0) ? $urandom : pc_pool[p];
            tgt = ($urandom_range(0, 5) == 0) ? $urandom : tgt_pool[p];
            tk = ($urandom_range(0, 3) != 0) ? p[0] : 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: ep = $urandom;
                1: ep = tk ? pc + 32'd4 : tgt;
                default: ep = tk ? tgt : pc + 32'd4;
            endcase
            if ($urandom_range(0, 1))
                add_req(OP_PREDICT, pc, $urandom, 1'($urandom_range(0, 1)), $urandom);
            add_req(OP_UPDATE, pc, tgt, tk, ep);
        end
    endtask

    initial begin
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings
        add_req(OP_PREDICT, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_req(OP_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);
        add_req(OP_UPDATE, 32'hFFFF_FFFC, 32'h0, 1'b1, 32'h0);
        add_req(OP_UPDATE, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
        add_req(OP_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678);
        add_req(OP_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
        for (int k = 0; k < 4; k++) add_req(OP_UPDATE, 32'h100, 32'h800, 1'b1, 32'h800);
        add_req(OP_PREDICT, 32'h100, 32'h0, 1'b0, 32'h0);
        add_req(OP_UPDATE, 32'h100 | (32'h1 << 7), 32'h900, 1'b1, 32'h104);
        add_req(OP_PREDICT, 32'h100, 32'h0, 1'b0, 32'h0);
        for (int k = 0; k < 4; k++) add_req(OP_UPDATE, 32'h180, 32'h900, 1'b0, 32'h184);
        add_req(OP_PREDICT, 32'h180, 32'h0, 1'b0, 32'h0);
        add_req(OP_UPDATE, 32'h180, 32'hAAAA_5555, 1'b0, 32'h0);
        add_req(OP_PREDICT, 32'h180, 32'h0, 1'b0, 32'h0);
        random_items(120);
        drain();

        write_all(5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'(SHARE_NONE));
        random_items(120);
        drain();
        write_all(5'd7, 5'd15, 5'd31, 5'd3, 5'd1, 5'd1, 5'd3);
        random_items(120);
        drain();
        write_all(5'd5, 5'd0, 5'd30, 5'd2, 5'd1, 5'd0, 5'(SHARE_LOW));
        random_items(120);
        drain();
        write_all(5'd6, 5'd8, 5'd25, 5'd1, 5'd0, 5'd1, 5'(SHARE_MID));
        random_items(120);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            write_all(5'($urandom_range(0, 7)), 5'($urandom_range(0, 15)),
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 3)),
                      5'($urandom_range(0, 1)), 5'($urandom_range(0, 1)),
                      5'($urandom_range(0, 3)));
            if (ph == 4) quiet = 1;
            random_items(120);
            drain();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bpu_pkg.sv
hw/rtl/bpu_entry_mem.sv
hw/rtl/bpu_ctr_mem.sv
hw/rtl/btb_two_level_branch_predictor_top.sv
tb/btb_two_level_branch_predictor_top_test.sv
